### hw/rtl/mlnp_pkg.sv
`default_nettype none
package mlnp_pkg;

  localparam int STACK_DEPTH     = 128;
  localparam int MAX_EVENT_BYTES = 4;
  localparam int NOTE_COUNT      = 128;

  localparam int NOTE_W = $clog2(NOTE_COUNT);
  localparam int STK_AW = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] STATUS_MASK     = 8'hF0;
  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;

  localparam logic [NOTE_W-1:0] RESET_NOTE = NOTE_W'(69);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_POP_RD,
    S_POP_HELD,
    S_POP_CHK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic changed;
    logic gate_on;
    logic gate_off;
    logic ignored;
    logic overflow;
  } res_flags_t;

  typedef struct packed {
    logic              en;
    logic [NOTE_W-1:0] addr;
    logic              data;
  } held_wr_t;

  typedef struct packed {
    logic              en;
    logic [STK_AW-1:0] addr;
    logic [NOTE_W-1:0] data;
  } stack_wr_t;

endpackage
`default_nettype wire

### hw/rtl/mlnp_ram.sv
`default_nettype none
module mlnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/mlnp_ctrl.sv
`default_nettype none
module mlnp_ctrl import mlnp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        event_length,
  input  logic [7:0]        status_byte,
  input  logic [7:0]        note_number,
  input  logic [7:0]        velocity,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NOTE_W-1:0] current_note,
  output logic              note_changed,
  output logic              gate_on_event,
  output logic              gate_off_event,
  output logic              voice_active,
  output logic              event_ignored,
  output logic              stack_overflow,
  output held_wr_t          held_wr,
  output logic [NOTE_W-1:0] held_raddr,
  input  logic              held_rdata,
  output stack_wr_t         stack_wr,
  output logic [STK_AW-1:0] stack_raddr,
  input  logic [NOTE_W-1:0] stack_rdata
);

  state_t            state, state_next;
  logic [NOTE_W-1:0] clr_addr;
  logic [NOTE_W-1:0] ev_note;
  logic              ev_ignored;
  logic              ev_on;
  logic [CNT_W-1:0]  stack_count, stack_count_next;
  logic [NOTE_W-1:0] top_note, top_note_next;
  logic [NOTE_W-1:0] sounding, sounding_next;
  res_flags_t        res, res_next;
  logic [CNT_W-1:0]  cnt_dec;
  logic              top_hit;
  logic              out_free;
  logic [7:0]        status_hi;

  assign status_hi = status_byte & STATUS_MASK;
  assign cnt_dec   = stack_count - CNT_W'(1);
  assign top_hit   = (stack_count != '0) && (top_note == ev_note);
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      stack_count <= '0;
      sounding    <= RESET_NOTE;
    end else begin
      state       <= state_next;
      clr_addr    <= (state == S_CLEAR) ? clr_addr + NOTE_W'(1) : clr_addr;
      stack_count <= stack_count_next;
      sounding    <= sounding_next;
    end
  end

  // decoded event, captured on the input transfer
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      ev_note    <= note_number[NOTE_W-1:0];
      ev_on      <= (status_hi == STATUS_NOTE_ON) && (velocity != 8'd0);
      ev_ignored <= (event_length > 8'(MAX_EVENT_BYTES)) ||
                    ((status_hi != STATUS_NOTE_ON) && (status_hi != STATUS_NOTE_OFF)) ||
                    note_number[7];
    end
    top_note <= top_note_next;
    res      <= res_next;
  end

  always_comb begin
    state_next       = state;
    stack_count_next = stack_count;
    top_note_next    = top_note;
    sounding_next    = sounding;
    res_next         = res;
    held_wr          = '0;
    held_raddr       = stack_rdata;
    stack_wr         = '0;
    stack_raddr      = cnt_dec[STK_AW-1:0];
    case (state)
      S_CLEAR: begin
        held_wr.en   = 1'b1;
        held_wr.addr = clr_addr;
        held_wr.data = 1'b0;
        if (clr_addr == NOTE_W'(NOTE_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_next         = '0;
        res_next.ignored = ev_ignored;
        state_next       = S_FIN;
        if (!ev_ignored) begin
          held_wr.en   = 1'b1;
          held_wr.addr = ev_note;
          held_wr.data = ev_on;
          if (ev_on && !top_hit) begin
            sounding_next    = ev_note;
            res_next.changed = 1'b1;
            res_next.gate_on = (stack_count == '0);
            if (stack_count < CNT_W'(STACK_DEPTH)) begin
              stack_wr.en      = 1'b1;
              stack_wr.addr    = stack_count[STK_AW-1:0];
              stack_wr.data    = ev_note;
              stack_count_next = stack_count + CNT_W'(1);
              top_note_next    = ev_note;
            end else begin
              res_next.overflow = 1'b1;
            end
          end else if (!ev_on && top_hit) begin
            // released note on top: pop it, and start the pop walk unless the stack is now empty
            stack_count_next = cnt_dec;
            if (cnt_dec == '0) begin
              res_next.gate_off = 1'b1;
            end else begin
              state_next = S_POP_RD;
            end
          end
        end
      end
      S_POP_RD: begin
        state_next = S_POP_HELD;
      end
      S_POP_HELD: begin
        top_note_next = stack_rdata;
        state_next    = S_POP_CHK;
      end
      S_POP_CHK: begin
        state_next = S_FIN;
        if (held_rdata) begin
          sounding_next    = top_note;
          res_next.changed = 1'b1;
        end else begin
          stack_count_next = cnt_dec;
          if (cnt_dec == '0) begin
            res_next.gate_off = 1'b1;
          end else begin
            state_next = S_POP_RD;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      current_note   <= sounding;
      note_changed   <= res.changed;
      gate_on_event  <= res.gate_on;
      gate_off_event <= res.gate_off;
      event_ignored  <= res.ignored;
      stack_overflow <= res.overflow;
      voice_active   <= (stack_count != '0);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_RD || state == S_POP_HELD || state == S_POP_CHK) |-> stack_count != '0)
    else $error("pop walk on empty stack");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == S_EXEC)
    else $error("transfer not followed by execute");

  a_gate_off_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && gate_off_event) |-> (!voice_active && !gate_on_event && !note_changed))
    else $error("gate off with active voice");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && res.overflow) |-> stack_count == CNT_W'(STACK_DEPTH))
    else $error("overflow flagged on a stack that is not full");
`endif

endmodule
`default_nettype wire

### hw/rtl/mono_last_note_priority_stack_top.sv
`default_nettype none
// monophonic last-note-priority note stack: one result per accepted midi event. after reset
// the held-note bitmap is swept clear across all 128 notes, during which no event is taken.
// an event then goes through capture, execute and result when no pop is needed; a release
// of the top note pops it during execute and then walks the entries below it, each step of
// the walk reading the stack memory and then the held-note memory, one synchronous read
// after the other. the next event is taken as soon as the result has moved to the output
// register.
module mono_last_note_priority_stack_top import mlnp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        event_length,
  input  logic [7:0]        status_byte,
  input  logic [7:0]        note_number,
  input  logic [7:0]        velocity,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NOTE_W-1:0] current_note,
  output logic              note_changed,
  output logic              gate_on_event,
  output logic              gate_off_event,
  output logic              voice_active,
  output logic              event_ignored,
  output logic              stack_overflow
);

  held_wr_t          held_wr;
  logic [NOTE_W-1:0] held_raddr;
  logic              held_rdata;
  stack_wr_t         stack_wr;
  logic [STK_AW-1:0] stack_raddr;
  logic [NOTE_W-1:0] stack_rdata;

  mlnp_ram #(
    .WIDTH(1),
    .DEPTH(NOTE_COUNT)
  ) u_held_ram (
    .clk  (clk),
    .we   (held_wr.en),
    .waddr(held_wr.addr),
    .wdata(held_wr.data),
    .raddr(held_raddr),
    .rdata(held_rdata)
  );

  mlnp_ram #(
    .WIDTH(NOTE_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stack_wr.en),
    .waddr(stack_wr.addr),
    .wdata(stack_wr.data),
    .raddr(stack_raddr),
    .rdata(stack_rdata)
  );

  mlnp_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .event_length  (event_length),
    .status_byte   (status_byte),
    .note_number   (note_number),
    .velocity      (velocity),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .current_note  (current_note),
    .note_changed  (note_changed),
    .gate_on_event (gate_on_event),
    .gate_off_event(gate_off_event),
    .voice_active  (voice_active),
    .event_ignored (event_ignored),
    .stack_overflow(stack_overflow),
    .held_wr       (held_wr),
    .held_raddr    (held_raddr),
    .held_rdata    (held_rdata),
    .stack_wr      (stack_wr),
    .stack_raddr   (stack_raddr),
    .stack_rdata   (stack_rdata)
  );

endmodule
`default_nettype wire
